// ----- hw/rtl/bbs_pkg.sv -----
// Shared constants, types and helpers for the B-spline surface point unit.
// No dependencies.
package bbs_pkg;

  localparam int GRID_SIDE   = 11;
  localparam int NPTS        = GRID_SIDE * GRID_SIDE;
  localparam int SEGS        = GRID_SIDE - 3;
  localparam int COORD_WIDTH = 32;
  localparam int IDX_W       = 7;
  localparam int PAR_W       = 20;
  localparam int SEG_W       = 3;
  localparam int W_W         = 17;
  localparam int ROW_W       = COORD_WIDTH + 18;
  localparam int RRND_W      = ROW_W - 16;
  localparam int ACC_W       = RRND_W + 18;
  localparam int ONE_Q16     = 65536;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // one grid tap travelling with its read data
  typedef struct packed {
    logic       vld;
    logic [1:0] i;
    logic [1:0] j;
  } tap_t;

  // weights of one parameter
  typedef struct packed {
    logic                      vld;
    logic                      tag;
    logic [SEG_W-1:0]          seg;
    logic [3:0][W_W-1:0]       w;
  } wgt_t;

  typedef struct packed {
    logic   vld;
    coord_t x;
    coord_t y;
    coord_t z;
  } res_t;

  // floor(q / 6) for q below 2^19: halve, then reciprocal of three
  function automatic logic [W_W-1:0] div6(input logic [18:0] q);
    logic [37:0] m;
    m = 38'(q[18:1]) * 38'(349526);
    return W_W'(m >> 20);
  endfunction

endpackage

// ----- hw/rtl/bbs_in_if.sv -----
// Input channel: write or evaluate items with valid/ready handshake.
// Depends on bbs_pkg.
interface bbs_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bbs_pkg::IDX_W-1:0]    point_index;
  bbs_pkg::coord_t              point_x;
  bbs_pkg::coord_t              point_y;
  bbs_pkg::coord_t              point_z;
  logic signed [bbs_pkg::PAR_W-1:0] u_coord;
  logic signed [bbs_pkg::PAR_W-1:0] v_coord;

  modport source (output valid, kind, point_index, point_x, point_y, point_z,
                  u_coord, v_coord, input ready);
  modport sink   (input valid, kind, point_index, point_x, point_y, point_z,
                  u_coord, v_coord, output ready);
endinterface

// ----- hw/rtl/bbs_out_if.sv -----
// Output channel: evaluated surface points with valid/ready handshake.
// Depends on bbs_pkg.
interface bbs_out_if;
  logic            valid;
  logic            ready;
  bbs_pkg::coord_t surf_x;
  bbs_pkg::coord_t surf_y;
  bbs_pkg::coord_t surf_z;

  modport source (output valid, surf_x, surf_y, surf_z, input ready);
  modport sink   (input valid, surf_x, surf_y, surf_z, output ready);
endinterface

// ----- hw/rtl/bbs_grid_mem.sv -----
// Control point store: one word of x, y, z per grid entry, registered read.
// Depends on bbs_pkg.
module bbs_grid_mem (
  input  logic                      clk,
  input  logic                      we,
  input  logic [bbs_pkg::IDX_W-1:0] waddr,
  input  bbs_pkg::coord_t           wx,
  input  bbs_pkg::coord_t           wy,
  input  bbs_pkg::coord_t           wz,
  input  logic [bbs_pkg::IDX_W-1:0] raddr,
  output bbs_pkg::coord_t           rx,
  output bbs_pkg::coord_t           ry,
  output bbs_pkg::coord_t           rz
);
  logic [3*bbs_pkg::COORD_WIDTH-1:0] mem [bbs_pkg::NPTS];
  logic [3*bbs_pkg::COORD_WIDTH-1:0] rdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wx, wy, wz};
    end
    rdata <= mem[raddr];
  end

  assign rx = rdata[3*bbs_pkg::COORD_WIDTH-1 -: bbs_pkg::COORD_WIDTH];
  assign ry = rdata[2*bbs_pkg::COORD_WIDTH-1 -: bbs_pkg::COORD_WIDTH];
  assign rz = rdata[bbs_pkg::COORD_WIDTH-1:0];
endmodule

// ----- hw/rtl/bbs_weight.sv -----
// Basis weight pipeline: clamp a parameter, split segment and t, form the
// four Q0.16 cubic B-spline weights over five stages. Depends on bbs_pkg.
module bbs_weight (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            tag,
  input  logic signed [bbs_pkg::PAR_W-1:0] param,
  output bbs_pkg::wgt_t                   wgt
);
  logic [16:0] p;
  logic [19:0] scaled;
  logic [bbs_pkg::SEG_W-1:0] seg0;

  logic [4:0] vld;
  logic [4:0] tg;
  logic [bbs_pkg::SEG_W-1:0] seg1, seg2, seg3, seg4, seg5;
  logic [16:0] t1, r1, t2, r2;
  logic [33:0] tt2, rr2, tt3;
  logic [48:0] t3, r3;
  logic [18:0] q0, q1, q3;
  logic [52:0] n1;
  logic [bbs_pkg::W_W-1:0] w0, w1, w3;

  always_comb begin
    if (param[bbs_pkg::PAR_W-1]) begin
      p = '0;
    end else if (param > bbs_pkg::PAR_W'(bbs_pkg::ONE_Q16)) begin
      p = 17'(bbs_pkg::ONE_Q16);
    end else begin
      p = param[16:0];
    end
    scaled = 20'(p) * 20'(bbs_pkg::SEGS);
    if (scaled[19:16] > 4'(bbs_pkg::SEGS - 1)) begin
      seg0 = bbs_pkg::SEG_W'(bbs_pkg::SEGS - 1);
    end else begin
      seg0 = scaled[16+bbs_pkg::SEG_W-1:16];
    end
    n1 = 53'(3) * 53'(t3) + (53'(1) << 50) - ((53'(6) * 53'(tt3)) << 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[3:0], start};
    end
    tg   <= {tg[3:0], tag};
    t1   <= 17'(scaled - (20'(seg0) << 16));
    r1   <= 17'(20'(bbs_pkg::ONE_Q16) - (scaled - (20'(seg0) << 16)));
    seg1 <= seg0;
    tt2  <= 34'(t1) * 34'(t1);
    rr2  <= 34'(r1) * 34'(r1);
    t2   <= t1;
    r2   <= r1;
    seg2 <= seg1;
    tt3  <= tt2;
    t3   <= 49'(49'(tt2) * 49'(t2));
    r3   <= 49'(49'(rr2) * 49'(r2));
    seg3 <= seg2;
    q0   <= 19'((50'(r3) + (50'(3) << 32)) >> 32);
    q1   <= 19'((n1 + (53'(3) << 32)) >> 32);
    q3   <= 19'((50'(t3) + (50'(3) << 32)) >> 32);
    seg4 <= seg3;
    w0   <= bbs_pkg::div6(q0);
    w1   <= bbs_pkg::div6(q1);
    w3   <= bbs_pkg::div6(q3);
    seg5 <= seg4;
  end

  // tt3 carries the square one stage on so n1 lines up with t3
  assign wgt.vld = vld[4];
  assign wgt.tag = tg[4];
  assign wgt.seg = seg5;
  assign wgt.w[0] = w0;
  assign wgt.w[1] = w1;
  assign wgt.w[3] = w3;
  assign wgt.w[2] = bbs_pkg::W_W'(18'(bbs_pkg::ONE_Q16) - 18'(w0) - 18'(w1) - 18'(w3));
endmodule

// ----- hw/rtl/bbs_mac.sv -----
// Tensor-product accumulator: weights each tap by its v weight, rounds the
// row sums, weights them by u and rounds and saturates. Depends on bbs_pkg.
module bbs_mac (
  input  logic                    clk,
  input  logic                    rst,
  input  bbs_pkg::tap_t           tap,
  input  bbs_pkg::coord_t         px,
  input  bbs_pkg::coord_t         py,
  input  bbs_pkg::coord_t         pz,
  input  logic [3:0][bbs_pkg::W_W-1:0] wu,
  input  logic [3:0][bbs_pkg::W_W-1:0] wv,
  output bbs_pkg::res_t           res
);
  localparam int RW = bbs_pkg::ROW_W;
  localparam int NW = bbs_pkg::RRND_W;
  localparam int AW = bbs_pkg::ACC_W;
  localparam int CW = bbs_pkg::COORD_WIDTH;

  typedef logic signed [RW-1:0] row_t;
  typedef logic signed [AW-1:0] acc_t;

  bbs_pkg::tap_t tap2;
  logic          rdone;
  logic [1:0]    ri;
  logic          pdone;
  logic [1:0]    pi;
  logic          adone;
  row_t          prod [3];
  row_t          row  [3];
  acc_t          prod2 [3];
  acc_t          acc  [3];

  logic signed [CW-1:0] pin [3];
  logic signed [17:0]   wvs, wus;
  logic signed [NW-1:0] rr  [3];
  logic signed [AW-17:0] fr [3];
  logic signed [CW-1:0] sat [3];

  assign pin[0] = px;
  assign pin[1] = py;
  assign pin[2] = pz;
  assign wvs = $signed({1'b0, wv[tap.j]});
  assign wus = $signed({1'b0, wu[ri]});

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rr[c] = NW'((row[c] + row_t'(32768)) >>> 16);
      fr[c] = (AW-16)'((acc[c] + acc_t'(32768)) >>> 16);
      if (fr[c] > (AW-16)'(signed'({1'b0, {(CW-1){1'b1}}}))) begin
        sat[c] = {1'b0, {(CW-1){1'b1}}};
      end else if (fr[c] < -(AW-16)'(signed'({1'b0, {(CW-1){1'b1}}})) - 1) begin
        sat[c] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        sat[c] = CW'(fr[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap2.vld <= 1'b0;
      rdone    <= 1'b0;
      pdone    <= 1'b0;
      adone    <= 1'b0;
      res.vld  <= 1'b0;
    end else begin
      tap2.vld <= tap.vld;
      rdone    <= tap2.vld && (tap2.j == 2'd3);
      pdone    <= rdone;
      adone    <= pdone && (pi == 2'd3);
      res.vld  <= adone;
    end
    tap2.i <= tap.i;
    tap2.j <= tap.j;
    ri     <= tap2.i;
    pi     <= ri;
    for (int c = 0; c < 3; c++) begin
      prod[c] <= row_t'(pin[c]) * row_t'(wvs);
      if (tap2.vld) begin
        row[c] <= (tap2.j == 2'd0) ? prod[c] : row[c] + prod[c];
      end
      prod2[c] <= acc_t'(rr[c]) * acc_t'(wus);
      if (pdone) begin
        acc[c] <= (pi == 2'd0) ? prod2[c] : acc[c] + prod2[c];
      end
    end
    if (adone) begin
      res.x <= sat[0];
      res.y <= sat[1];
      res.z <= sat[2];
    end
  end
endmodule

// ----- hw/rtl/bicubic_bspline_surface_point.sv -----
// Uniform bicubic B-spline surface point unit with an 11 by 11 control grid.
// Write item: stored at the accepting edge, no result.
// Evaluate item: the input stays busy until its result is loaded into the
// output register, so a new item is not taken before the last is done. The
// 16 grid reads, one per cycle from the single read port, take the bulk of that time.
// Reset (synchronous, rst high) clears control only; grid contents stay.
module bicubic_bspline_surface_point (
  input  logic      clk,
  input  logic      rst,
  bbs_in_if.sink    req,
  bbs_out_if.source rsp
);
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_WGT_U  = 7'b0000010,
    ST_WGT_V  = 7'b0000100,
    ST_WGT_W  = 7'b0001000,
    ST_RUN    = 7'b0010000,
    ST_DRAIN  = 7'b0100000,
    ST_FIN    = 7'b1000000
  } state_t;

  state_t state, state_next;

  logic signed [bbs_pkg::PAR_W-1:0] u_reg, v_reg;
  logic [bbs_pkg::SEG_W-1:0] su, sv;
  logic [3:0][bbs_pkg::W_W-1:0] wu, wv;
  logic wv_got;
  logic [3:0] k;
  bbs_pkg::tap_t tap;
  bbs_pkg::wgt_t wgt;
  bbs_pkg::res_t res;
  logic acc_in, mem_we, w_start, w_tag;
  logic signed [bbs_pkg::PAR_W-1:0] w_param;
  logic [3:0] row;
  logic [bbs_pkg::IDX_W-1:0] raddr;
  bbs_pkg::coord_t rx, ry, rz;
  logic out_free;

  assign req.ready = (state == ST_IDLE);
  assign acc_in    = req.valid && req.ready;
  assign mem_we    = acc_in && (req.kind == bbs_pkg::KIND_WRITE) &&
                     (req.point_index < bbs_pkg::IDX_W'(bbs_pkg::NPTS));
  assign w_start   = (state == ST_WGT_U) || (state == ST_WGT_V);
  assign w_tag     = (state == ST_WGT_V);
  assign w_param   = (state == ST_WGT_V) ? v_reg : u_reg;
  assign row       = 4'(su) + 4'(k[3:2]);
  assign raddr     = bbs_pkg::IDX_W'(row) * bbs_pkg::IDX_W'(bbs_pkg::GRID_SIDE) +
                     bbs_pkg::IDX_W'(sv) + bbs_pkg::IDX_W'(k[1:0]);
  assign out_free  = !rsp.valid || rsp.ready;

  bbs_grid_mem u_mem (
    .clk, .we(mem_we), .waddr(req.point_index),
    .wx(req.point_x), .wy(req.point_y), .wz(req.point_z),
    .raddr, .rx, .ry, .rz
  );

  bbs_weight u_wgt (
    .clk, .rst, .start(w_start), .tag(w_tag), .param(w_param), .wgt
  );

  bbs_mac u_mac (
    .clk, .rst, .tap, .px(rx), .py(ry), .pz(rz), .wu, .wv, .res
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (acc_in && req.kind == bbs_pkg::KIND_EVAL) state_next = ST_WGT_U;
      ST_WGT_U: state_next = ST_WGT_V;
      ST_WGT_V: state_next = ST_WGT_W;
      ST_WGT_W: if (wgt.vld && wgt.tag) state_next = ST_RUN;
      ST_RUN:   if (k == 4'd15) state_next = ST_DRAIN;
      ST_DRAIN: if (res.vld) state_next = ST_FIN;
      ST_FIN:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      k         <= '0;
      tap.vld   <= 1'b0;
      rsp.valid <= 1'b0;
      wv_got    <= 1'b0;
    end else begin
      state   <= state_next;
      tap.vld <= (state == ST_RUN);
      if (state == ST_RUN) begin
        k <= k + 4'd1;
      end else begin
        k <= '0;
      end
      wv_got <= wgt.vld && wgt.tag;
      if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (state == ST_FIN && out_free) begin
        rsp.valid <= 1'b1;
      end
    end
    tap.i <= k[3:2];
    tap.j <= k[1:0];
    if (acc_in) begin
      u_reg <= req.u_coord;
      v_reg <= req.v_coord;
    end
    if (wgt.vld && !wgt.tag) begin
      su <= wgt.seg;
      wu <= wgt.w;
    end
    if (wgt.vld && wgt.tag) begin
      sv <= wgt.seg;
      wv <= wgt.w;
    end
    if (state == ST_FIN && out_free) begin
      rsp.surf_x <= res.x;
      rsp.surf_y <= res.y;
      rsp.surf_z <= res.z;
    end
  end

  a_res_in_drain: assert property (@(posedge clk) disable iff (rst)
    res.vld |-> state == ST_DRAIN) else $error("result outside drain");
  a_fin_loads: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FIN && out_free) |=> (rsp.valid && state == ST_IDLE))
    else $error("finished result not presented");
  a_eval_start: assert property (@(posedge clk) disable iff (rst)
    (acc_in && req.kind == bbs_pkg::KIND_EVAL) |=> state == ST_WGT_U)
    else $error("evaluate item did not start weights");
  a_run_weights: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && k == 4'd0) |-> $past(wv_got) || wv_got || $past(state) == ST_WGT_W)
    else $error("run started without weights");
endmodule

// ----- sim/bbs_in_if.sv -----
`timescale 1ns / 100ps
// Testbench copy note: the channel interfaces live with the RTL; this file
// holds nothing but a small helper package for the surface point testbench.
// Depends on bbs_pkg.
package bbs_tb_pkg;
  import bbs_pkg::*;

  typedef struct {
    logic [COORD_WIDTH-1:0] x;
    logic [COORD_WIDTH-1:0] y;
    logic [COORD_WIDTH-1:0] z;
  } surf_point_t;
endpackage

// ----- sim/bicubic_bspline_surface_point_tb.sv -----
`timescale 1ns / 100ps
// Testbench for the bicubic B-spline surface point unit: loads the control
// grid, evaluates points and checks them against an in-bench predictor.
// Depends on bbs_pkg, bbs_tb_pkg, bbs_in_if, bbs_out_if and the RTL top.
module bicubic_bspline_surface_point_tb;
  import bbs_pkg::*;
  import bbs_tb_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic clk;
  logic rst;
  bbs_in_if  req ();
  bbs_out_if rsp ();

  bicubic_bspline_surface_point DUT (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  longint      pt_x [NPTS];
  longint      pt_y [NPTS];
  longint      pt_z [NPTS];
  bit          pt_set [NPTS];
  surf_point_t pending_points [$];
  int          src_idle_pct;
  int          snk_idle_pct;
  int          hold_cycles;
  int          mismatches;
  int          checked;
  int          idle_cycles;
  int          eval_count;
  int          write_count;
  bit          timed_out;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_q16(longint a);
    return (a + 32768) >>> 16;
  endfunction

  // clamp parameter to [0,1], return segment and basis weights
  function automatic int basis_weights(logic [PAR_W-1:0] raw, output longint w[4]);
    longint p, scaled, seg, t, r, n0, n1, n3;
    longint dv, half;
    dv = longint'(6) <<< 32;
    half = longint'(3) <<< 32;
    p = longint'($signed(raw));
    if (p < 0) p = 0;
    if (p > ONE_Q16) p = ONE_Q16;
    scaled = p * SEGS;
    seg = scaled >>> 16;
    if (seg > SEGS - 1) seg = SEGS - 1;
    t = scaled - seg * ONE_Q16;
    r = ONE_Q16 - t;
    n3 = t * t * t;
    n0 = r * r * r;
    n1 = 3 * n3 - 6 * (t * t) * ONE_Q16 + (longint'(4) <<< 48);
    w[0] = (n0 + half) / dv;
    w[1] = (n1 + half) / dv;
    w[3] = (n3 + half) / dv;
    w[2] = ONE_Q16 - w[0] - w[1] - w[3];
    return int'(seg);
  endfunction

  function automatic logic [COORD_WIDTH-1:0] blend_axis(ref longint g[NPTS], input int su,
      input int sv, input longint wu[4], input longint wv[4]);
    longint acc, row, lim;
    acc = 0;
    lim = (longint'(1) <<< (COORD_WIDTH - 1));
    for (int i = 0; i < 4; i++) begin
      row = 0;
      for (int j = 0; j < 4; j++) row += wv[j] * g[(su + i) * GRID_SIDE + sv + j];
      acc += wu[i] * round_q16(row);
    end
    acc = round_q16(acc);
    if (acc > lim - 1) acc = lim - 1;
    if (acc < -lim) acc = -lim;
    return acc[COORD_WIDTH-1:0];
  endfunction

  function automatic bit patch_loaded(logic [PAR_W-1:0] u, logic [PAR_W-1:0] v);
    longint wu[4], wv[4];
    int su, sv;
    su = basis_weights(u, wu);
    sv = basis_weights(v, wv);
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++)
        if (!pt_set[(su + i) * GRID_SIDE + sv + j]) return 1'b0;
    return 1'b1;
  endfunction

  // send one item; predict its result when accepted; valid stays up for the next
  task automatic send_item(logic k, logic [IDX_W-1:0] idx, logic [31:0] x,
      logic [31:0] y, logic [31:0] z, logic [PAR_W-1:0] u, logic [PAR_W-1:0] v);
    longint wu[4], wv[4];
    int su, sv;
    surf_point_t sp;
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.kind <= k;
    req.point_index <= idx;
    req.point_x <= x;
    req.point_y <= y;
    req.point_z <= z;
    req.u_coord <= u;
    req.v_coord <= v;
    do @(posedge clk); while (!req.ready);
    if (k == KIND_WRITE) begin
      write_count++;
      if (idx < NPTS) begin
        pt_x[idx] = longint'($signed(x));
        pt_y[idx] = longint'($signed(y));
        pt_z[idx] = longint'($signed(z));
        pt_set[idx] = 1'b1;
      end
    end else begin
      eval_count++;
      su = basis_weights(u, wu);
      sv = basis_weights(v, wv);
      sp.x = blend_axis(pt_x, su, sv, wu, wv);
      sp.y = blend_axis(pt_y, su, sv, wu, wv);
      sp.z = blend_axis(pt_z, su, sv, wu, wv);
      pending_points.push_back(sp);
    end
    @(negedge clk);
  endtask

  task automatic write_point(int idx, logic [31:0] x, logic [31:0] y, logic [31:0] z);
    send_item(KIND_WRITE, idx[IDX_W-1:0], x, y, z, PAR_W'($urandom), PAR_W'($urandom));
  endtask

  task automatic eval_point(logic [PAR_W-1:0] u, logic [PAR_W-1:0] v);
    send_item(KIND_EVAL, IDX_W'($urandom), $urandom, $urandom, $urandom, u, v);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (pending_points.size() != 0 && !timed_out) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  function automatic logic [PAR_W-1:0] random_param();
    case ($urandom_range(9))
      0: return PAR_W'($urandom);
      1: return PAR_W'(ONE_Q16);
      2: return '0;
      3: return PAR_W'($urandom_range(ONE_Q16 + 200, ONE_Q16 - 200));
      default: return PAR_W'($urandom_range(ONE_Q16));
    endcase
  endfunction

  task automatic test_directed();
    // fill the whole grid: two in four entries get extremes, the other two random points
    for (int k = 0; k < NPTS; k++) begin
      case (k % 4)
        0: write_point(k, 32'h7fff_ffff, 32'h8000_0000, 32'h0);
        1: write_point(k, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
        default: write_point(k, $urandom, $urandom, $urandom);
      endcase
    end
    write_point(121, 32'h1234, 32'h5678, 32'h9abc);
    write_point(127, 32'h1234, 32'h5678, 32'h9abc);
    eval_point(20'h80000, 20'h7ffff);
    eval_point(20'h7ffff, 20'h80000);
    eval_point('0, '0);
    eval_point(PAR_W'(ONE_Q16), PAR_W'(ONE_Q16));
    eval_point(PAR_W'(ONE_Q16 - 1), 20'h0_2000);
    eval_point(20'hfffff, PAR_W'(ONE_Q16 + 1));
    eval_point(20'h0_8000, 20'h0_4000);
    for (int k = 0; k < NPTS; k++) write_point(k, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    eval_point(20'h0_8000, 20'h0_8000);
    eval_point(PAR_W'(ONE_Q16), '0);
    wait_drained();
  endtask

  task automatic test_random(int count);
    int idx;
    for (int n = 0; n < count && !timed_out; n++) begin
      if ($urandom_range(2) == 0) begin
        idx = $urandom_range(3) == 0 ? $urandom_range(127) : $urandom_range(NPTS - 1);
        if ($urandom_range(3) == 0)
          write_point(idx, $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000, $urandom,
                      $urandom);
        else
          write_point(idx, $signed($urandom_range(2000000)) - 1000000, $urandom, $urandom);
      end else begin
        eval_point(random_param(), random_param());
      end
    end
  endtask

  // stall the receiver long enough for the block to back up
  task automatic test_backpressure();
    hold_cycles = 300;
    for (int n = 0; n < 6; n++) eval_point(random_param(), random_param());
    wait_drained();
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready) begin
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected surface point %h %h %h",
                                       rsp.surf_x, rsp.surf_y, rsp.surf_z);
      end else begin
        surf_point_t e;
        e = pending_points.pop_front();
        checked++;
        if (e.x !== rsp.surf_x || e.y !== rsp.surf_y || e.z !== rsp.surf_z) begin
          mismatches++;
          if (mismatches <= 10)
            $display("point mismatch: expected %h %h %h got %h %h %h",
                     e.x, e.y, e.z, rsp.surf_x, rsp.surf_y, rsp.surf_z);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("bicubic_bspline_surface_point test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.kind = KIND_WRITE;
    req.point_index = '0;
    req.point_x = '0;
    req.point_y = '0;
    req.point_z = '0;
    req.u_coord = '0;
    req.v_coord = '0;
    rsp.ready = 1'b0;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_cycles = 0;
    mismatches = 0;
    checked = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    for (int k = 0; k < NPTS; k++) pt_set[k] = 1'b0;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    test_directed();
    src_idle_pct = 13;
    snk_idle_pct = 71;
    test_random(550);
    test_backpressure();
    src_idle_pct = 71;
    snk_idle_pct = 13;
    test_random(550);
    wait_drained();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random(550);
    wait_drained();
    $display("sent %0d writes and %0d evaluations, checked %0d surface points",
             write_count, eval_count, checked);
    $display("covered clamped, boundary and saturating parameters under stalls");
    if (mismatches == 0 && pending_points.size() == 0)
      $display("bicubic_bspline_surface_point test passed");
    else
      $display("bicubic_bspline_surface_point test failed");
    $finish;
  end
endmodule
